// ===== hw/rtl/mmn_pkg.sv =====
// shared types and constants for the min-max normalise to byte block
// no dependencies; used by every module of the block
package mmn_pkg;

	// sample format: signed fixed point
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 8;

	// difference width, two bits spare so that a negation cannot overflow
	localparam int DIFF_WIDTH = VALUE_WIDTH + 2;

	// gray level width and the divider that produces it
	localparam int QUO_BITS  = 8;
	localparam int CNT_WIDTH = $clog2(QUO_BITS);
	localparam int REM_WIDTH = DIFF_WIDTH + QUO_BITS;

	// decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// sample kinds
	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	// gray limits
	localparam logic [QUO_BITS-1:0] GRAY_MIN = '0;
	localparam logic [QUO_BITS-1:0] GRAY_MAX = '1;

	// one convert job handed from front to back
	typedef struct packed {
		logic signed [DIFF_WIDTH-1:0] diff;   // value minus effective minimum
		logic signed [DIFF_WIDTH-1:0] span;   // effective maximum minus minimum
		logic                         equal;  // extremes coincide
	} job_t;

endpackage

// ===== hw/rtl/mmn_front.sv =====
// front part: accepts samples, tracks frame extremes, builds convert jobs
// depends on mmn_pkg
module mmn_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_ready,
	input  logic                                    kind,
	input  logic signed [mmn_pkg::VALUE_WIDTH-1:0]  value,
	input  logic                                    first_of_frame,
	input  logic                                    queue_full,
	output logic                                    push,
	output mmn_pkg::job_t                           job
);

	localparam int VW = mmn_pkg::VALUE_WIDTH;
	localparam int DW = mmn_pkg::DIFF_WIDTH;
	localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] TOP =
		VW'(255) << mmn_pkg::FRACTION_BITS;

	logic signed [VW-1:0] min_q, max_q;
	logic signed [VW-1:0] lo_eff, hi_eff;
	logic                 in_byte;
	logic                 beat;

	// a measure beat is absorbed here, a convert beat is pushed; both wait while the queue is full
	assign sample_ready = !queue_full;
	assign beat         = sample_valid && sample_ready;
	assign push         = beat && (kind == mmn_pkg::KIND_CONVERT);

	// running extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MOST_POS;
			max_q <= MOST_NEG;
		end else if (beat && (kind == mmn_pkg::KIND_MEASURE)) begin
			if (first_of_frame) begin
				min_q <= value;
				max_q <= value;
			end else begin
				if (value < min_q) min_q <= value;
				if (value > max_q) max_q <= value;
			end
		end
	end

	// extremes inside the byte range fall back to the full 0..255 scale
	assign in_byte = (min_q >= 0) && (min_q <= TOP) && (max_q >= 0) && (max_q <= TOP);
	assign lo_eff  = in_byte ? '0  : min_q;
	assign hi_eff  = in_byte ? TOP : max_q;

	// job snapshot, so later measure beats cannot disturb it
	always_comb begin
		job.diff  = DW'(value) - DW'(lo_eff);
		job.span  = DW'(hi_eff) - DW'(lo_eff);
		job.equal = (hi_eff == lo_eff);
	end

endmodule

// ===== hw/rtl/mmn_queue.sv =====
// two-entry job queue that decouples front and back
// depends on mmn_pkg
module mmn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mmn_pkg::job_t push_job,
	input  logic          pop,
	output mmn_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);

	localparam int QD = mmn_pkg::QDEPTH;
	localparam int QA = mmn_pkg::QAW;

	mmn_pkg::job_t        slot_q [QD];
	logic [QA-1:0]        wr_ptr_q, rd_ptr_q;
	logic [QA:0]          count_q;

	assign full     = (count_q == (QA+1)'(QD));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QA'(QD-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QA'(QD-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/mmn_back.sv =====
// back part: sign fix-up, clamping and restoring division to one gray byte
// depends on mmn_pkg
module mmn_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              queue_empty,
	input  mmn_pkg::job_t                     head_job,
	output logic                              pop,
	output logic [mmn_pkg::QUO_BITS-1:0]      gray,
	output logic                              gray_valid,
	input  logic                              gray_ready
);

	localparam int DW = mmn_pkg::DIFF_WIDTH;
	localparam int RW = mmn_pkg::REM_WIDTH;
	localparam int QB = mmn_pkg::QUO_BITS;
	localparam int CW = mmn_pkg::CNT_WIDTH;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0]            state_q;
	logic signed [DW-1:0]  diff_q, span_q;
	logic                  equal_q;
	logic [RW-1:0]         rem_q, dsh_q;
	logic [QB-1:0]         quo_q;
	logic [CW-1:0]         cnt_q;
	logic [QB-1:0]         gray_q;
	logic                  valid_q;

	logic signed [DW-1:0]  diff_n, span_n;
	logic [RW-1:0]         diff_w, num, dsh_init;
	logic                  ge;
	logic [QB-1:0]         quo_next;

	// take a job only when the output register is free
	assign pop = (state_q == ST_IDLE) && !queue_empty && !valid_q;

	// make the span positive, carrying the sign into the numerator
	always_comb begin
		diff_n   = span_q[DW-1] ? -diff_q : diff_q;
		span_n   = span_q[DW-1] ? -span_q : span_q;
		diff_w   = RW'(unsigned'(diff_n));
		num      = (diff_w << QB) - diff_w;
		dsh_init = RW'(unsigned'(span_n)) << (QB-1);
	end

	// one restoring step
	assign ge       = (rem_q >= dsh_q);
	assign quo_next = {quo_q[QB-2:0], ge};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (valid_q && gray_ready) valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					if (equal_q || diff_n <= 0 || diff_n >= span_n) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QB-1)) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					diff_q  <= head_job.diff;
					span_q  <= head_job.span;
					equal_q <= head_job.equal;
				end
			end
			ST_SETUP: begin
				rem_q <= num;
				dsh_q <= dsh_init;
				quo_q <= '0;
				if (equal_q || diff_n <= 0) gray_q <= mmn_pkg::GRAY_MIN;
				else if (diff_n >= span_n)  gray_q <= mmn_pkg::GRAY_MAX;
			end
			ST_DIV: begin
				if (ge) rem_q <= rem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				if (cnt_q == CW'(QB-1)) gray_q <= quo_next;
			end
			default: ;
		endcase
	end

	assign gray       = gray_q;
	assign gray_valid = valid_q;

endmodule

// ===== hw/rtl/min_max_normalize_to_byte.sv =====
// Min-max contrast stretch of signed Q24.8 samples to 8-bit gray. A measure
// sample (kind 0) updates the frame minimum and maximum, restarting them on
// first_of_frame, and is taken without producing any output beat. A convert
// sample (kind 1) is queued with a snapshot of the extremes and yields one
// gray beat, floor((v-min)*255/(max-min)) clamped to 0..255, with the range
// 0..255 used when both extremes lie inside it and 0 when they are equal.
// The back part works on one convert sample at a time (load, setup, eight
// restoring division steps, one bit per cycle) before the beat is offered;
// clamped cases finish after setup. The next job is loaded in the cycle after
// the beat is taken, so it never starts a job while a beat waits. A two-entry
// queue lets the front keep accepting samples while a division is running;
// while the queue is full every sample waits.
// depends on mmn_pkg, mmn_front, mmn_queue, mmn_back
module min_max_normalize_to_byte (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_ready,
	input  logic                                    kind,
	input  logic signed [mmn_pkg::VALUE_WIDTH-1:0]  value,
	input  logic                                    first_of_frame,
	output logic                                    gray_valid,
	input  logic                                    gray_ready,
	output logic [mmn_pkg::QUO_BITS-1:0]            gray
);

	logic          push, pop, full, empty;
	mmn_pkg::job_t push_job, head_job;

	// front: classification and extreme tracking
	mmn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.kind           (kind),
		.value          (value),
		.first_of_frame (first_of_frame),
		.queue_full     (full),
		.push           (push),
		.job            (push_job)
	);

	// job queue
	mmn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (full),
		.empty    (empty)
	);

	// back: division and output register
	mmn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (empty),
		.head_job    (head_job),
		.pop         (pop),
		.gray        (gray),
		.gray_valid  (gray_valid),
		.gray_ready  (gray_ready)
	);

endmodule

// ===== tb/sv/min_max_normalize_to_byte_tb.sv =====
// self-checking testbench for min_max_normalize_to_byte: directed corner samples,
// then random measure/convert frames under varying idle, stall and back-pressure
// depends on mmn_pkg and the min_max_normalize_to_byte rtl
module min_max_normalize_to_byte_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mmn_pkg::*;

	localparam int     CLK_PERIOD   = 10;
	localparam int     RESET_CYCLES = 8;
	localparam int     PHASE_ITEMS  = 455;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     DRAIN_CYCLES = 30;
	localparam int     QUIET_LIMIT  = 2000;
	localparam longint FULL_SCALE   = 255;
	localparam longint VMAX         = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
	localparam longint VMIN         = -VMAX - 1;
	localparam longint BYTE_TOP     = FULL_SCALE << FRACTION_BITS;

	// expected gray levels, predicted from a private copy of the frame extremes
	class gray_scoreboard;
		longint                frame_min;
		longint                frame_max;
		logic [QUO_BITS-1:0]   gray_due[$];
		int                    errors;

		function new();
			frame_min = VMAX;
			frame_max = VMIN;
			errors    = 0;
		endfunction

		// contrast stretch of one sample against the tracked extremes
		function logic [QUO_BITS-1:0] stretch(longint v);
			longint lo, hi, num, den;
			lo = frame_min;
			hi = frame_max;
			if (lo >= 0 && lo <= BYTE_TOP && hi >= 0 && hi <= BYTE_TOP) begin
				lo = 0;
				hi = BYTE_TOP;
			end
			if (hi == lo)
				return GRAY_MIN;
			num = (v - lo) * FULL_SCALE;
			den = hi - lo;
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num <= 0)
				return GRAY_MIN;
			if (num >= den * FULL_SCALE)
				return GRAY_MAX;
			return QUO_BITS'(num / den);
		endfunction

		// accepted sample beat: track extremes or queue a gray level
		function void note_sample(logic k, logic signed [VALUE_WIDTH-1:0] v, logic f);
			longint sv;
			sv = longint'(v);
			if (k == KIND_CONVERT)
				gray_due.push_back(stretch(sv));
			else if (f) begin
				frame_min = sv;
				frame_max = sv;
			end else begin
				if (sv < frame_min)
					frame_min = sv;
				if (sv > frame_max)
					frame_max = sv;
			end
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: gray check failed: %s", $time, what);
			errors++;
		endtask

		// accepted gray beat against the oldest expectation
		task check_gray(logic [QUO_BITS-1:0] got);
			logic [QUO_BITS-1:0] due;
			if (gray_due.size() == 0) begin
				report_mismatch($sformatf("beat %0d with nothing due", got));
				return;
			end
			due = gray_due.pop_front();
			if (got !== due)
				report_mismatch($sformatf("got %0d, due %0d", got, due));
		endtask

		function int pending();
			return gray_due.size();
		endfunction
	endclass

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            sample_valid   = 1'b0;
	logic                            sample_ready;
	logic                            kind           = KIND_MEASURE;
	logic signed [VALUE_WIDTH-1:0]   value          = '0;
	logic                            first_of_frame = 1'b0;
	logic                            gray_valid;
	logic                            gray_ready     = 1'b0;
	logic [QUO_BITS-1:0]             gray;

	gray_scoreboard sb = new();

	int send_idle_pct  = 0;
	int gray_stall_pct = 0;
	int samples_sent   = 0;
	bit pressure_go    = 1'b0;
	bit hold_off       = 1'b0;

	min_max_normalize_to_byte DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.kind           (kind),
		.value          (value),
		.first_of_frame (first_of_frame),
		.gray_valid     (gray_valid),
		.gray_ready     (gray_ready),
		.gray           (gray)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stalls, plus one long hold-off
	always @(negedge clk) begin
		gray_ready <= !hold_off && ($urandom_range(99) >= gray_stall_pct);
	end

	// long hold-off counted in its own process so that the block fills up
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// output beats go to the scoreboard
	always @(posedge clk) begin
		if (arst_n && gray_valid && gray_ready)
			sb.check_gray(gray);
	end

	// watchdog: too long without any beat on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sample_valid && sample_ready) || (gray_valid && gray_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint clamp_word(longint x);
		if (x > VMAX)
			return VMAX;
		if (x < VMIN)
			return VMIN;
		return x;
	endfunction

	function automatic longint rand_word();
		logic signed [VALUE_WIDTH-1:0] w;
		w = VALUE_WIDTH'({$urandom, $urandom});
		return longint'(w);
	endfunction

	function automatic longint pick_between(longint lo, longint hi);
		longint unsigned r;
		r = {$urandom, $urandom};
		return lo + longint'(r % longint'(hi - lo + 1));
	endfunction

	// one sample beat; called and left at a falling edge
	task automatic send_sample(logic k, longint v, logic f);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid   <= 1'b1;
		kind           <= k;
		value          <= VALUE_WIDTH'(v);
		first_of_frame <= f;
		do
			@(posedge clk);
		while (!sample_ready);
		sb.note_sample(kind, value, first_of_frame);
		samples_sent++;
		@(negedge clk);
	endtask

	// measure pass then convert pass over a range of random shape
	task automatic run_frame();
		int     n_meas, n_conv, pick;
		longint a, b, t, v;
		case ($urandom_range(9))
			0, 1, 2: begin
				a = rand_word();
				b = rand_word();
			end
			3, 4: begin
				a = rand_word();
				b = clamp_word(a + longint'($urandom_range(0, 4096)));
			end
			5, 6: begin
				a = longint'($urandom_range(0, 32'(BYTE_TOP)));
				b = longint'($urandom_range(0, 32'(BYTE_TOP)));
			end
			7: begin
				a = longint'($urandom_range(0, 2000)) - 1000;
				b = longint'($urandom_range(60000, 70000));
			end
			8: begin
				a = rand_word();
				b = a;
			end
			default: begin
				a = rand_word();
				b = clamp_word(a + longint'($urandom_range(1, 3)));
			end
		endcase
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		n_meas = $urandom_range(1, 6);
		for (int i = 0; i < n_meas; i++) begin
			if (i == 0)
				v = a;
			else if (i == n_meas - 1)
				v = b;
			else
				v = pick_between(a, b);
			// mostly a fresh frame, sometimes carrying on from the last one
			send_sample(KIND_MEASURE, v, i == 0 && $urandom_range(9) != 0);
		end
		n_conv = $urandom_range(1, 12);
		for (int i = 0; i < n_conv; i++) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				// stray measure in the middle of the convert pass
				send_sample(KIND_MEASURE, rand_word(), 1'b0);
				continue;
			end
			if (pick < 70)
				v = pick_between(a, b);
			else if (pick < 85)
				v = clamp_word(pick_between(a - 2000, b + 2000));
			else
				v = rand_word();
			send_sample(KIND_CONVERT, v, 1'($urandom_range(1)));
		end
	endtask

	// full output hold-off while the sender keeps offering converts
	task automatic pressure_burst();
		send_idle_pct  = 0;
		gray_stall_pct = 0;
		pressure_go    = 1'b1;
		send_sample(KIND_MEASURE, -50000, 1'b1);
		send_sample(KIND_MEASURE, 900000, 1'b0);
		for (int i = 0; i < 30; i++)
			send_sample(KIND_CONVERT, longint'($urandom_range(0, 1000000)) - 100000,
				1'b0);
	endtask

	initial begin : stimulus
		int target;
		int idle_pct[4];
		int stall_pct[4];
		idle_pct  = '{0, 52, 0, 22};
		stall_pct = '{0, 0, 52, 22};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// convert before any measure: reset extremes, min above max
		send_sample(KIND_CONVERT, 0, 1'b0);
		send_sample(KIND_CONVERT, VMAX, 1'b0);
		send_sample(KIND_CONVERT, VMIN, 1'b0);
		// full-scale extremes
		send_sample(KIND_MEASURE, VMIN, 1'b1);
		send_sample(KIND_MEASURE, VMAX, 1'b0);
		send_sample(KIND_CONVERT, 0, 1'b1);
		send_sample(KIND_CONVERT, VMIN, 1'b0);
		send_sample(KIND_CONVERT, VMAX, 1'b0);
		send_sample(KIND_CONVERT, -1, 1'b0);
		// extremes inside the byte range, with clamps either side
		send_sample(KIND_MEASURE, 100 << FRACTION_BITS, 1'b1);
		send_sample(KIND_MEASURE, 200 << FRACTION_BITS, 1'b0);
		send_sample(KIND_CONVERT, 128 << FRACTION_BITS, 1'b0);
		send_sample(KIND_CONVERT, 300 << FRACTION_BITS, 1'b0);
		send_sample(KIND_CONVERT, -5, 1'b0);
		// byte range edges exactly
		send_sample(KIND_MEASURE, 0, 1'b1);
		send_sample(KIND_MEASURE, BYTE_TOP, 1'b0);
		send_sample(KIND_CONVERT, BYTE_TOP, 1'b0);
		// equal extremes
		send_sample(KIND_MEASURE, -1000, 1'b1);
		send_sample(KIND_CONVERT, -1000, 1'b0);
		send_sample(KIND_CONVERT, 5, 1'b0);
		// just above the byte range
		send_sample(KIND_MEASURE, BYTE_TOP + 1, 1'b1);
		send_sample(KIND_MEASURE, 0, 1'b0);
		send_sample(KIND_CONVERT, BYTE_TOP + 1, 1'b0);
		send_sample(KIND_CONVERT, 32000, 1'b0);

		// random frames across the idling phases, pressure in the middle
		target = samples_sent;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_pct[p];
			gray_stall_pct = stall_pct[p];
			target += PHASE_ITEMS;
			while (samples_sent < target)
				run_frame();
			if (p == 1)
				pressure_burst();
		end
		sample_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
